@@ hw/rtl/rbvi_pkg.sv @@
// rigid body velocity integrator: shared types, constants and helpers
// no dependencies
package rbvi_pkg;

  localparam int unsigned VecW  = 48;
  localparam int unsigned CompW = 16;

  typedef enum logic [1:0] {
    REG_TIME_STEP = 2'd0,
    REG_GRAVITY_X = 2'd1,
    REG_GRAVITY_Y = 2'd2,
    REG_GRAVITY_Z = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] TIME_STEP_RST = 16'd1092;
  localparam logic [15:0] GRAVITY_X_RST = 16'h0000;
  localparam logic [15:0] GRAVITY_Y_RST = 16'hF631;
  localparam logic [15:0] GRAVITY_Z_RST = 16'h0000;

  // stage 1 to stage 2 product set, one entry per component, two's complement bits
  typedef struct packed {
    logic               active;
    logic [VecW-1:0]    lin;
    logic [VecW-1:0]    ang;
    logic [2:0][32:0]   gs;
    logic [2:0][32:0]   fm;
    logic [2:0][33:0]   it;
    logic [24:0]        klin;
    logic [24:0]        kang;
  } s1_t;

  function automatic logic signed [15:0] lane(input logic [VecW-1:0] v, input int k);
    lane = v[k*CompW +: CompW];
  endfunction

endpackage

@@ hw/rtl/rbvi_finish.sv @@
// rigid body velocity integrator: per-component round, damp and clamp
// uses rbvi_pkg; pipelined two register stages after the delta
module rbvi_finish (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] vel,
  input  logic signed [50:0] delta,
  input  logic [24:0]        factor,
  output logic signed [15:0] res,
  output logic               sat
);
  import rbvi_pkg::*;

  logic signed [41:0] und_nxt, und_r;
  logic signed [68:0] prod_nxt, prod_r;
  logic signed [36:0] rnd;
  logic signed [52:0] sum;

  // round to q.16: add half and floor
  assign sum     = {{13{vel[15]}}, vel, 24'd0} + 53'(delta) + 53'sd32768;
  assign und_nxt = 42'(sum >>> 16);
  assign prod_nxt = 69'(und_r) * $signed({1'b0, factor});
  assign rnd = 37'((prod_r + 69'sd2147483648) >>> 32);

  always_ff @(posedge clk) begin
    if (en) begin
      und_r  <= und_nxt;
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    sat = 1'b0;
    res = rnd[15:0];
    if (rnd > 37'sd32767) begin
      res = 16'sh7FFF;
      sat = 1'b1;
    end else if (rnd < -37'sd32768) begin
      res = 16'sh8000;
      sat = 1'b1;
    end
  end
endmodule

@@ hw/rtl/rigid_body_velocity_integrator_unit.sv @@
// rigid body velocity integrator: top level, config registers, product stage, pipeline control
// uses rbvi_pkg and rbvi_finish
// throughput: one body per cycle while the output is not stalled
// stages: products and inertia sums, dt multiply, round, damp multiply, output register
// the whole pipeline advances together and freezes only when the output is full and stalled
// reset: synchronous active-low, clears valid bits and loads the register defaults
// payload registers are not reset
module rigid_body_velocity_integrator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [47:0]          in_linear_velocity,
  input  logic [47:0]          in_angular_velocity,
  input  logic [47:0]          in_force_sum,
  input  logic [47:0]          in_torque_sum,
  input  logic [47:0]          in_inertia_diagonal,
  input  logic [47:0]          in_inertia_off_diagonal,
  input  logic [15:0]          in_inverse_mass,
  input  logic signed [15:0]   in_gravity_scale,
  input  logic [15:0]          in_linear_damping,
  input  logic [15:0]          in_angular_damping,
  input  logic                 in_body_active,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [47:0]          out_new_linear_velocity,
  output logic [47:0]          out_new_angular_velocity,
  output logic                 out_saturated
);
  import rbvi_pkg::*;

  logic [15:0] time_step_r;
  logic signed [15:0] grav_r [3];
  logic [4:0] vld_r;
  logic en;

  assign en        = !vld_r[4] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RST;
      grav_r[0]   <= GRAVITY_X_RST;
      grav_r[1]   <= GRAVITY_Y_RST;
      grav_r[2]   <= GRAVITY_Z_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TIME_STEP: time_step_r <= cfg_data;
        REG_GRAVITY_X: grav_r[0]   <= cfg_data;
        REG_GRAVITY_Y: grav_r[1]   <= cfg_data;
        REG_GRAVITY_Z: grav_r[2]   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[3:0], in_valid};
  end

  // stage 1: products, inertia sums and damping factors
  s1_t s1_nxt, s1_r;
  logic signed [15:0] ine [3][3];
  logic signed [33:0] kl, ka;

  always_comb begin
    ine[0][0] = lane(in_inertia_diagonal, 0);
    ine[1][1] = lane(in_inertia_diagonal, 1);
    ine[2][2] = lane(in_inertia_diagonal, 2);
    ine[0][1] = lane(in_inertia_off_diagonal, 0);
    ine[1][0] = ine[0][1];
    ine[0][2] = lane(in_inertia_off_diagonal, 1);
    ine[2][0] = ine[0][2];
    ine[1][2] = lane(in_inertia_off_diagonal, 2);
    ine[2][1] = ine[1][2];
    s1_nxt.active = in_body_active;
    s1_nxt.lin    = in_linear_velocity;
    s1_nxt.ang    = in_angular_velocity;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.gs[i] = 33'(grav_r[i]) * 33'(in_gravity_scale);
      s1_nxt.fm[i] = 33'(lane(in_force_sum, i)) * $signed({17'd0, in_inverse_mass});
      s1_nxt.it[i] = 34'(ine[i][0]) * 34'(lane(in_torque_sum, 0))
                   + 34'(ine[i][1]) * 34'(lane(in_torque_sum, 1))
                   + 34'(ine[i][2]) * 34'(lane(in_torque_sum, 2));
    end
    kl = 34'sd16777216 - $signed({2'b0, 32'(in_linear_damping) * 32'(time_step_r)});
    ka = 34'sd16777216 - $signed({2'b0, 32'(in_angular_damping) * 32'(time_step_r)});
    s1_nxt.klin = kl[33] ? 25'd0 : kl[24:0];
    s1_nxt.kang = ka[33] ? 25'd0 : ka[24:0];
  end

  always_ff @(posedge clk) if (en) s1_r <= s1_nxt;

  // stage 2: multiply by dt
  logic signed [50:0] dl_r [3], da_r [3];
  logic [47:0] lin2_r, ang2_r, lin3_r, ang3_r, lin4_r, ang4_r;
  logic [24:0] kl2_r, ka2_r, kl3_r, ka3_r;
  logic [2:0] act_r;
  logic signed [16:0] ts;
  assign ts = $signed({1'b0, time_step_r});

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dl_r[i] <= (51'($signed(s1_r.gs[i])) + 51'($signed(s1_r.fm[i]))) * 51'(ts);
        da_r[i] <= 51'($signed(s1_r.it[i])) * 51'(ts);
      end
      lin2_r <= s1_r.lin; ang2_r <= s1_r.ang;
      kl2_r  <= s1_r.klin; ka2_r <= s1_r.kang;
      lin3_r <= lin2_r; ang3_r <= ang2_r;
      kl3_r  <= kl2_r; ka3_r <= ka2_r;
      lin4_r <= lin3_r; ang4_r <= ang3_r;
      act_r  <= {act_r[1:0], s1_r.active};
    end
  end

  logic signed [15:0] rl [3], ra [3];
  logic [5:0] sv;
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_comp
      rbvi_finish u_lin (.clk, .en, .vel(lane(lin2_r, g)), .delta(dl_r[g]),
                         .factor(kl3_r), .res(rl[g]), .sat(sv[g]));
      rbvi_finish u_ang (.clk, .en, .vel(lane(ang2_r, g)), .delta(da_r[g]),
                         .factor(ka3_r), .res(ra[g]), .sat(sv[g+3]));
    end
  endgenerate

  // output register; lin4/ang4 align with finish output
  always_ff @(posedge clk) begin
    if (en) begin
      if (act_r[2]) begin
        out_new_linear_velocity  <= {rl[2], rl[1], rl[0]};
        out_new_angular_velocity <= {ra[2], ra[1], ra[0]};
        out_saturated            <= |sv;
      end else begin
        out_new_linear_velocity  <= lin4_r;
        out_new_angular_velocity <= ang4_r;
        out_saturated            <= 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_linear_velocity))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("pipeline stalled while output empty");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0]) else $error("accepted item lost");
endmodule
